@@ rtl/core/sspq_pkg.sv @@
// Types and constants shared by the stable sorted priority queue.
// No dependencies.
package sspq_pkg;

  localparam int unsigned PRIO_W = 8;
  localparam int unsigned PAY_W  = 16;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  typedef struct packed {
    logic              operation;
    logic [PRIO_W-1:0] priority_req;
    logic [PAY_W-1:0]  payload;
  } req_t;

  typedef struct packed {
    logic              out_valid;
    logic [PRIO_W-1:0] out_priority;
    logic [PAY_W-1:0]  out_payload;
    logic              was_empty;
    logic              dropped;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

@@ rtl/core/stable_sorted_priority_queue.sv @@
// Top level of the stable sorted priority queue.
// Depends on sspq_pkg, sspq_ctrl and sspq_dpath.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------
//  request | in_valid_i/in_ready_o | in_req_i  (req_t)
//  result  | out_valid_o/out_ready_i | out_rsp_o (rsp_t)
//
// Each request is first captured into the request register and then executed,
// with every slot comparing and shifting in parallel; no new request is taken until then.
// Execute waits only while the result register holds an untaken result.
// After reset the queue is empty; no clearing pass.
module stable_sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sspq_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sspq_pkg::rsp_t out_rsp_o
);

  sspq_pkg::cmd_t cmd;

  sspq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  sspq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_req_i),
    .rsp_o  (out_rsp_o)
  );

endmodule

@@ rtl/core/sspq_ctrl.sv @@
// Controller of the priority queue: request sequencing and result handshake.
// Depends on sspq_pkg.
module sspq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sspq_pkg::cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.execute = (state_q == ST_EXEC) && (!rsp_valid_q || out_ready_i);
  assign out_valid_o   = rsp_valid_q;

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    if (out_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_o.execute) begin
          state_d     = ST_IDLE;
          rsp_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |-> (!rsp_valid_q || out_ready_i))
    else $error("execute would overwrite a pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> rsp_valid_q)
    else $error("result not presented after execute");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_EXEC))
    else $error("captured request not executed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !out_ready_i) |=> rsp_valid_q)
    else $error("pending result dropped");

endmodule

@@ rtl/core/sspq_dpath.sv @@
// Datapath of the priority queue: request register, sorted slot row with
// per-slot compare and shift, entry count and result register.
// Depends on sspq_pkg.
module sspq_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sspq_pkg::cmd_t cmd_i,
  input  sspq_pkg::req_t req_i,
  output sspq_pkg::rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  sspq_pkg::req_t              req_q;
  sspq_pkg::rsp_t              rsp_q, rsp_d;
  logic [sspq_pkg::PRIO_W-1:0] prio_q [DEPTH];
  logic [sspq_pkg::PAY_W-1:0]  pay_q  [DEPTH];
  logic [CntW-1:0]             count_q, count_d;
  logic [DEPTH-1:0]            ge;
  logic                        full, empty, is_deq, do_deq, do_enq;

  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);
  assign is_deq = (req_q.operation == sspq_pkg::OP_DEQUEUE);
  assign do_deq = cmd_i.execute && is_deq && !empty;
  assign do_enq = cmd_i.execute && !is_deq && !full;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    assign ge[i] = (CntW'(i) < count_q) && (prio_q[i] >= req_q.priority_req);

    always_ff @(posedge clk_i) begin
      if (do_deq) begin
        if (i < DEPTH - 1) begin
          prio_q[i] <= prio_q[(i + 1) % DEPTH];
          pay_q[i]  <= pay_q[(i + 1) % DEPTH];
        end
      end else if (do_enq && !ge[i]) begin
        if (i == 0 || ge[(i + DEPTH - 1) % DEPTH]) begin
          prio_q[i] <= req_q.priority_req;
          pay_q[i]  <= req_q.payload;
        end else begin
          prio_q[i] <= prio_q[(i + DEPTH - 1) % DEPTH];
          pay_q[i]  <= pay_q[(i + DEPTH - 1) % DEPTH];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_deq) begin
      count_d = count_q - CntW'(1);
    end else if (do_enq) begin
      count_d = count_q + CntW'(1);
    end
    rsp_d              = '0;
    rsp_d.occupancy    = sspq_pkg::OCC_W'(count_d);
    rsp_d.dropped      = !is_deq && full;
    rsp_d.was_empty    = is_deq && empty;
    rsp_d.out_valid    = is_deq && !empty;
    if (is_deq && !empty) begin
      rsp_d.out_priority = prio_q[0];
      rsp_d.out_payload  = pay_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.execute && !is_deq && !full) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the queue");

endmodule

@@ tb/stable_sorted_priority_queue_tb.sv @@
// Testbench for stable_sorted_priority_queue: random and directed enqueue/dequeue requests
// checked against a shadow sorted queue. Depends on sspq_pkg and the queue RTL.
`timescale 1ns / 1ps

module stable_sorted_priority_queue_tb;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned RAND_ITEMS = 900;

  logic           clk_i;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  sspq_pkg::req_t in_req_i    = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  sspq_pkg::rsp_t out_rsp_o;

  sspq_pkg::req_t req_backlog[$];
  sspq_pkg::rsp_t predicted_rsps[$];

  logic [sspq_pkg::PRIO_W-1:0] shadow_prio[DEPTH];
  logic [sspq_pkg::PAY_W-1:0]  shadow_payload[DEPTH];
  int unsigned                 shadow_count = 0;

  logic req_taken = 1'b0;
  int   cyc       = 0;
  int   errors    = 0;
  logic calm;

  assign calm = (cyc >= 1500) && (cyc < 2500);

  stable_sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic sspq_pkg::rsp_t sorted_queue_step(sspq_pkg::req_t r);
    sspq_pkg::rsp_t rsp;
    int unsigned    pos;
    rsp = '0;
    if (r.operation == sspq_pkg::OP_DEQUEUE) begin
      if (shadow_count == 0) begin
        rsp.was_empty = 1'b1;
      end else begin
        rsp.out_valid    = 1'b1;
        rsp.out_priority = shadow_prio[0];
        rsp.out_payload  = shadow_payload[0];
        for (int unsigned i = 1; i < shadow_count; i++) begin
          shadow_prio[i-1]    = shadow_prio[i];
          shadow_payload[i-1] = shadow_payload[i];
        end
        shadow_count--;
      end
    end else if (shadow_count >= DEPTH) begin
      rsp.dropped = 1'b1;
    end else begin
      pos = 0;
      while (pos < shadow_count && shadow_prio[pos] >= r.priority_req) pos++;
      for (int unsigned i = shadow_count; i > pos; i--) begin
        shadow_prio[i]    = shadow_prio[i-1];
        shadow_payload[i] = shadow_payload[i-1];
      end
      shadow_prio[pos]    = r.priority_req;
      shadow_payload[pos] = r.payload;
      shadow_count++;
    end
    rsp.occupancy = sspq_pkg::OCC_W'(shadow_count);
    return rsp;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("ERROR %0t: %s expected %0h got %0h", $time, what, want, got);
    errors++;
  endtask

  task automatic queue_request(sspq_pkg::op_e op, logic [sspq_pkg::PRIO_W-1:0] prio,
                               logic [sspq_pkg::PAY_W-1:0] pay);
    sspq_pkg::req_t r;
    r.operation    = op;
    r.priority_req = prio;
    r.payload      = pay;
    req_backlog.push_back(r);
  endtask

  function automatic logic [sspq_pkg::PRIO_W-1:0] pick_priority();
    logic [sspq_pkg::PRIO_W-1:0] p;
    case ($urandom_range(3))
      0: p = sspq_pkg::PRIO_W'($urandom_range(3));
      1: p = $urandom_range(1) ? '1 : '0;
      default: p = sspq_pkg::PRIO_W'($urandom);
    endcase
    return p;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= calm || ($urandom_range(99) >= 33);
      if (!in_valid_i || req_taken) begin
        if (req_backlog.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
          in_req_i   <= req_backlog.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    sspq_pkg::rsp_t want;
    if (rst_ni) begin
      cyc++;
      req_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        predicted_rsps.push_back(sorted_queue_step(in_req_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (predicted_rsps.size() == 0) begin
          flag_mismatch("unexpected result", 32'h0, 32'(out_rsp_o));
        end else begin
          want = predicted_rsps.pop_front();
          if (out_rsp_o.out_valid !== want.out_valid)
            flag_mismatch("out_valid", 32'(want.out_valid), 32'(out_rsp_o.out_valid));
          if (out_rsp_o.out_priority !== want.out_priority)
            flag_mismatch("out_priority", 32'(want.out_priority),
                          32'(out_rsp_o.out_priority));
          if (out_rsp_o.out_payload !== want.out_payload)
            flag_mismatch("out_payload", 32'(want.out_payload),
                          32'(out_rsp_o.out_payload));
          if (out_rsp_o.was_empty !== want.was_empty)
            flag_mismatch("was_empty", 32'(want.was_empty), 32'(out_rsp_o.was_empty));
          if (out_rsp_o.dropped !== want.dropped)
            flag_mismatch("dropped", 32'(want.dropped), 32'(out_rsp_o.dropped));
          if (out_rsp_o.occupancy !== want.occupancy)
            flag_mismatch("occupancy", 32'(want.occupancy), 32'(out_rsp_o.occupancy));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned                 issued;
    int unsigned                 seg_len;
    int unsigned                 enq_bias;
    logic [sspq_pkg::PRIO_W-1:0] dir_prio[8];

    dir_prio = '{8'h01, 8'hFE, 8'h80, 8'h55, 8'hAA, 8'h80, 8'h00, 8'hFF};

    queue_request(sspq_pkg::OP_DEQUEUE, '0, '0);
    queue_request(sspq_pkg::OP_ENQUEUE, 8'h80, 16'h0001);
    queue_request(sspq_pkg::OP_ENQUEUE, 8'h80, 16'h0002);
    queue_request(sspq_pkg::OP_ENQUEUE, 8'h00, 16'h0000);
    queue_request(sspq_pkg::OP_ENQUEUE, 8'hFF, 16'hFFFF);
    queue_request(sspq_pkg::OP_ENQUEUE, 8'h80, 16'h0003);
    queue_request(sspq_pkg::OP_ENQUEUE, 8'hFF, 16'h1234);
    queue_request(sspq_pkg::OP_ENQUEUE, 8'h00, 16'hAAAA);
    queue_request(sspq_pkg::OP_ENQUEUE, 8'h7F, 16'h5555);
    for (int i = 0; i < 8; i++) begin
      queue_request(sspq_pkg::OP_ENQUEUE, dir_prio[i], sspq_pkg::PAY_W'(16'h0100 + i));
    end
    queue_request(sspq_pkg::OP_ENQUEUE, 8'hFF, 16'hDEAD);
    queue_request(sspq_pkg::OP_DEQUEUE, 8'hFF, 16'hFFFF);
    for (int i = 0; i < 3; i++) begin
      queue_request(sspq_pkg::OP_DEQUEUE, '0, '0);
    end
    queue_request(sspq_pkg::OP_ENQUEUE, 8'h00, 16'h0000);

    issued = 0;
    while (issued < RAND_ITEMS) begin
      case ($urandom_range(2))
        0: enq_bias = 85;
        1: enq_bias = 50;
        default: enq_bias = 15;
      endcase
      seg_len = $urandom_range(20, 60);
      for (int unsigned k = 0; k < seg_len; k++) begin
        queue_request(($urandom_range(99) < enq_bias) ? sspq_pkg::OP_ENQUEUE
                                                       : sspq_pkg::OP_DEQUEUE,
                      pick_priority(), sspq_pkg::PAY_W'($urandom));
      end
      issued += seg_len;
    end

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() > 0 || in_valid_i) @(posedge clk_i);
    while (predicted_rsps.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
